FILE: design/nspc_pkg.sv
// ----------------------------------------------------------------------------
// nspc_pkg: shared types and constants for the nearest site pixel classifier
// Holds the default sizes, the function codes of a request beat and the
// width of a site index as it appears on the channels.
// ----------------------------------------------------------------------------
package nspc_pkg;

   localparam int NUM_SITES_DEF  = 10;
   localparam int COORD_BITS_DEF = 10;
   localparam int SITE_IDX_BITS  = 4;

   typedef enum logic {
      FUNC_LOAD     = 1'b0,
      FUNC_CLASSIFY = 1'b1
   } func_type;

   typedef logic [SITE_IDX_BITS-1:0] site_idx_type;

endpackage

FILE: design/nspc_req_if.sv
// ----------------------------------------------------------------------------
// nspc_req_if: request channel of the nearest site pixel classifier
// Carries one load or classify beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nspc_req_if #(
   parameter int COORD_BITS = nspc_pkg::COORD_BITS_DEF
);
   import nspc_pkg::*;

   logic                  valid;
   logic                  ready;
   func_type              func;
   site_idx_type          site_index;
   logic [COORD_BITS-1:0] coord_x;
   logic [COORD_BITS-1:0] coord_y;

   modport source (
      output valid,
      output func,
      output site_index,
      output coord_x,
      output coord_y,
      input  ready
   );

   modport sink (
      input  valid,
      input  func,
      input  site_index,
      input  coord_x,
      input  coord_y,
      output ready
   );

endinterface

FILE: design/nspc_rsp_if.sv
// ----------------------------------------------------------------------------
// nspc_rsp_if: response channel of the nearest site pixel classifier
// Carries the index of the nearest site with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nspc_rsp_if;
   import nspc_pkg::*;

   logic         valid;
   logic         ready;
   site_idx_type nearest_site;

   modport source (
      output valid,
      output nearest_site,
      input  ready
   );

   modport sink (
      input  valid,
      input  nearest_site,
      output ready
   );

endinterface

FILE: design/nearest_site_pixel_classifier.sv
// ----------------------------------------------------------------------------
// nearest_site_pixel_classifier: brute force nearest site lookup per pixel
// Keeps a table of site coordinates and returns, for each classified pixel,
// the index of the site at the smallest squared Euclidean distance. Ties go
// to the lowest index.
//
//   Channel   Direction  Beat contents
//   req_chan  in         func, site_index, coord_x, coord_y
//   rsp_chan  out        nearest_site (one beat per classify, none per load)
//
// One beat enters per cycle unless a result waits untaken at the output. The
// accepting edge loads the pixel register; the result then passes the difference,
// square and sum registers and one register per level of the minimum tree on its
// way to the output register.
// A load beat writes the site table at acceptance and leaves the pipeline.
// Reset clears the site table and all valid bits.
// When a result waits at the output, the whole pipeline and the request
// side hold until it is taken.
// ----------------------------------------------------------------------------
module nearest_site_pixel_classifier #(
   parameter int NUM_SITES  = nspc_pkg::NUM_SITES_DEF,
   parameter int COORD_BITS = nspc_pkg::COORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   nspc_req_if.sink   req_chan,
   nspc_rsp_if.source rsp_chan
);
   import nspc_pkg::*;

   localparam int LEVELS    = $clog2(NUM_SITES);
   localparam int LEAVES    = 1 << LEVELS;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = 2 * COORD_BITS + 1;

   logic advance;
   logic req_fire;

   logic [COORD_BITS-1:0] site_x_ff [NUM_SITES];
   logic [COORD_BITS-1:0] site_y_ff [NUM_SITES];

   logic                  s1_valid_in;
   logic                  s1_valid_ff;
   logic [COORD_BITS-1:0] pix_x_ff;
   logic [COORD_BITS-1:0] pix_y_ff;

   logic                  s2_valid_ff;
   logic [COORD_BITS-1:0] dx_in [NUM_SITES];
   logic [COORD_BITS-1:0] dy_in [NUM_SITES];
   logic [COORD_BITS-1:0] dx_ff [NUM_SITES];
   logic [COORD_BITS-1:0] dy_ff [NUM_SITES];

   logic               s3_valid_ff;
   logic [SQ_BITS-1:0] sqx_ff [NUM_SITES];
   logic [SQ_BITS-1:0] sqy_ff [NUM_SITES];

   logic                 s4_valid_ff;
   logic [DIST_BITS-1:0] sum_ff [NUM_SITES];

   logic [DIST_BITS-1:0] node_dist [1:2*LEAVES-1];
   logic [LEVELS-1:0]    node_idx  [1:2*LEAVES-1];
   logic [DIST_BITS-1:0] tree_dist_ff [1:LEAVES-1];
   logic [LEVELS-1:0]    tree_idx_ff  [1:LEAVES-1];
   logic [LEVELS:0]      valid_chain;
   logic [LEVELS-1:0]    tree_valid_in;
   logic [LEVELS-1:0]    tree_valid_ff;

   assign advance        = !tree_valid_ff[0] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign req_fire       = req_chan.valid && advance;

   for (genvar i = 0; i < NUM_SITES; i++) begin : g_site
      always_ff @(posedge clock) begin
         if (reset) begin
            site_x_ff[i] <= '0;
            site_y_ff[i] <= '0;
         end else if (req_fire && req_chan.func == FUNC_LOAD &&
                      32'(req_chan.site_index) == i) begin
            site_x_ff[i] <= req_chan.coord_x;
            site_y_ff[i] <= req_chan.coord_y;
         end
      end
   end

   assign s1_valid_in = req_fire && req_chan.func == FUNC_CLASSIFY;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_x_ff <= req_chan.coord_x;
         pix_y_ff <= req_chan.coord_y;
      end
   end

   for (genvar i = 0; i < NUM_SITES; i++) begin : g_lane
      always_comb begin
         dx_in[i] = (site_x_ff[i] >= pix_x_ff) ? site_x_ff[i] - pix_x_ff
                                              : pix_x_ff - site_x_ff[i];
         dy_in[i] = (site_y_ff[i] >= pix_y_ff) ? site_y_ff[i] - pix_y_ff
                                              : pix_y_ff - site_y_ff[i];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dx_ff[i]  <= dx_in[i];
            dy_ff[i]  <= dy_in[i];
            sqx_ff[i] <= SQ_BITS'(dx_ff[i]) * SQ_BITS'(dx_ff[i]);
            sqy_ff[i] <= SQ_BITS'(dy_ff[i]) * SQ_BITS'(dy_ff[i]);
            sum_ff[i] <= DIST_BITS'(sqx_ff[i]) + DIST_BITS'(sqy_ff[i]);
         end
      end
   end

   // Unused leaves read as the largest distance so they never win.
   for (genvar k = 1; k < 2 * LEAVES; k++) begin : g_node
      if (k < LEAVES) begin : g_inner
         assign node_dist[k] = tree_dist_ff[k];
         assign node_idx[k]  = tree_idx_ff[k];
      end else if (k - LEAVES < NUM_SITES) begin : g_leaf
         assign node_dist[k] = sum_ff[k-LEAVES];
         assign node_idx[k]  = LEVELS'(k - LEAVES);
      end else begin : g_pad
         assign node_dist[k] = '1;
         assign node_idx[k]  = '0;
      end
   end

   // The left child covers the lower indices, so it keeps ties.
   for (genvar k = 1; k < LEAVES; k++) begin : g_tree
      always_ff @(posedge clock) begin
         if (advance) begin
            if (node_dist[2*k+1] < node_dist[2*k]) begin
               tree_dist_ff[k] <= node_dist[2*k+1];
               tree_idx_ff[k]  <= node_idx[2*k+1];
            end else begin
               tree_dist_ff[k] <= node_dist[2*k];
               tree_idx_ff[k]  <= node_idx[2*k];
            end
         end
      end
   end

   assign valid_chain   = {s4_valid_ff, tree_valid_ff};
   assign tree_valid_in = valid_chain[LEVELS:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_valid_ff <= '0;
      end else if (advance) begin
         tree_valid_ff <= tree_valid_in;
      end
   end

   assign rsp_chan.valid        = tree_valid_ff[0];
   assign rsp_chan.nearest_site = SITE_IDX_BITS'(tree_idx_ff[1]);

endmodule

FILE: design/nspc_checker.sv
// ----------------------------------------------------------------------------
// nspc_checker: port level checks for the nearest site pixel classifier
// Watches the handshakes and the result beat of the top level, and is bound
// to every instance of it.
// ----------------------------------------------------------------------------
module nspc_checker #(
   parameter int NUM_SITES = nspc_pkg::NUM_SITES_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input nspc_pkg::site_idx_type rsp_nearest_site
);
   import nspc_pkg::*;

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat offered right after reset");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not track the output register");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_nearest_site) < NUM_SITES))
      else $error("nearest site index beyond the site table");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_site))
      else $error("stalled result beat changed or vanished");

endmodule

bind nearest_site_pixel_classifier nspc_checker #(
   .NUM_SITES(NUM_SITES)
) u_nspc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_nearest_site(rsp_chan.nearest_site)
);

FILE: tb/nearest_site_pixel_classifier_test.sv
// ----------------------------------------------------------------------------
// nearest_site_pixel_classifier_test: self-checking bench for the classifier
// A table of directed beats covers reset state, extreme coordinates, dropped
// loads and ties. Random scenes follow, mixed with single random beats: a few
// site loads, then a burst of pixels on, between or near the sites or at random.
// Every classify result is compared with a software copy of the site table.
// ----------------------------------------------------------------------------
module nearest_site_pixel_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nspc_pkg::*;

   localparam int NUM_SITES    = NUM_SITES_DEF;
   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int IDLE_PCT     = 21;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int ITEM_TARGET  = 1450;
   localparam int NUM_DIRECTED = 21;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      func_type     func;
      site_idx_type site_index;
      coord_type    x;
      coord_type    y;
      logic         has_want;
      site_idx_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   nspc_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   nspc_rsp_if rsp_chan ();

   nearest_site_pixel_classifier #(
      .NUM_SITES (NUM_SITES),
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #1 clock = ~clock;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{FUNC_CLASSIFY, 4'd0,  10'd0,    10'd0,    1'b1, 4'd0},
      '{FUNC_CLASSIFY, 4'd15, 10'd1023, 10'd1023, 1'b1, 4'd0},
      '{FUNC_LOAD,     4'd9,  10'd1023, 10'd1023, 1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd1023, 10'd1023, 1'b1, 4'd9},
      '{FUNC_CLASSIFY, 4'd0,  10'd600,  10'd600,  1'b0, 4'd0},
      '{FUNC_LOAD,     4'd15, 10'd512,  10'd512,  1'b0, 4'd0},
      '{FUNC_LOAD,     4'd10, 10'd5,    10'd5,    1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd5,    10'd5,    1'b1, 4'd0},
      '{FUNC_LOAD,     4'd3,  10'd100,  10'd200,  1'b0, 4'd0},
      '{FUNC_LOAD,     4'd5,  10'd100,  10'd200,  1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd100,  10'd200,  1'b1, 4'd3},
      '{FUNC_LOAD,     4'd0,  10'd1023, 10'd0,    1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd0,    10'd0,    1'b1, 4'd1},
      '{FUNC_LOAD,     4'd1,  10'd0,    10'd1023, 1'b0, 4'd0},
      '{FUNC_LOAD,     4'd2,  10'd1023, 10'd1023, 1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd1000, 10'd1000, 1'b1, 4'd2},
      '{FUNC_LOAD,     4'd4,  10'd200,  10'd300,  1'b0, 4'd0},
      '{FUNC_LOAD,     4'd6,  10'd204,  10'd300,  1'b0, 4'd0},
      '{FUNC_CLASSIFY, 4'd0,  10'd202,  10'd300,  1'b1, 4'd4},
      '{FUNC_CLASSIFY, 4'd0,  10'd1023, 10'd0,    1'b1, 4'd0},
      '{FUNC_CLASSIFY, 4'd7,  10'd512,  10'd700,  1'b0, 4'd0}
   };

   coord_type    site_x_copy [NUM_SITES];
   coord_type    site_y_copy [NUM_SITES];
   site_idx_type nearest_pending [$];

   int  mismatch_count;
   int  results_checked;
   int  beats_counted;
   int  loads_kept;
   int  loads_dropped;
   int  pixels_sent;
   int  tie_count;
   bit  hold_off_wanted;
   bit  quiet_phase;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @ %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic site_idx_type nearest_site_for(input coord_type px, input coord_type py);
      int           dx;
      int           dy;
      int           dist_sq;
      int           best_dist;
      site_idx_type best;
      bit           tied;
      best = '0;
      tied = 1'b0;
      best_dist = -1;
      for (int i = 0; i < NUM_SITES; i++) begin
         dx = int'(site_x_copy[i]) - int'(px);
         dy = int'(site_y_copy[i]) - int'(py);
         dist_sq = dx * dx + dy * dy;
         if (best_dist < 0 || dist_sq < best_dist) begin
            best_dist = dist_sq;
            best = site_idx_type'(i);
            tied = 1'b0;
         end else if (dist_sq == best_dist) begin
            tied = 1'b1;
         end
      end
      if (tied) tie_count++;
      return best;
   endfunction

   task automatic record_beat(input func_type f, input site_idx_type idx, input coord_type x,
                              input coord_type y, input logic has_want, input site_idx_type want);
      site_idx_type predicted;
      beats_counted++;
      if (f == FUNC_LOAD) begin
         if (idx < NUM_SITES) begin
            site_x_copy[idx] = x;
            site_y_copy[idx] = y;
            loads_kept++;
         end else begin
            loads_dropped++;
         end
      end else begin
         predicted = nearest_site_for(x, y);
         nearest_pending.push_back(has_want ? want : predicted);
         pixels_sent++;
      end
   endtask

   task automatic offer_beat(input func_type f, input site_idx_type idx, input coord_type x,
                             input coord_type y, input logic has_want, input site_idx_type want);
      while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= f;
      req_chan.site_index <= idx;
      req_chan.coord_x    <= x;
      req_chan.coord_y    <= y;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      record_beat(f, idx, x, y, has_want, want);
   endtask

   function automatic coord_type jitter(input coord_type c);
      int v;
      v = int'(c) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   task automatic random_scene();
      int           span;
      int           n_loads;
      int           n_pixels;
      int           a;
      int           b;
      site_idx_type idx;
      coord_type    x;
      coord_type    y;
      span = ($urandom_range(0, 3) == 0) ? 16 : COORD_MAX + 1;
      n_loads = $urandom_range(1, NUM_SITES);
      n_pixels = $urandom_range(5, 30);
      for (int i = 0; i < n_loads; i++) begin
         if ($urandom_range(0, 7) == 0) idx = site_idx_type'($urandom_range(NUM_SITES, 15));
         else idx = site_idx_type'($urandom_range(0, NUM_SITES - 1));
         if ($urandom_range(0, 5) == 0) begin
            a = $urandom_range(0, NUM_SITES - 1);
            x = site_x_copy[a];
            y = site_y_copy[a];
         end else begin
            x = coord_type'($urandom_range(0, span - 1));
            y = coord_type'($urandom_range(0, span - 1));
         end
         offer_beat(FUNC_LOAD, idx, x, y, 1'b0, '0);
      end
      for (int i = 0; i < n_pixels; i++) begin
         a = $urandom_range(0, NUM_SITES - 1);
         b = $urandom_range(0, NUM_SITES - 1);
         case ($urandom_range(0, 4))
            0: begin
               x = site_x_copy[a];
               y = site_y_copy[a];
            end
            1: begin
               x = coord_type'((int'(site_x_copy[a]) + int'(site_x_copy[b])) / 2);
               y = coord_type'((int'(site_y_copy[a]) + int'(site_y_copy[b])) / 2);
            end
            2: begin
               x = jitter(site_x_copy[a]);
               y = jitter(site_y_copy[a]);
            end
            3: begin
               x = coord_type'($urandom_range(0, COORD_MAX));
               y = coord_type'($urandom_range(0, COORD_MAX));
            end
            default: begin
               x = coord_type'($urandom_range(0, span - 1));
               y = coord_type'($urandom_range(0, span - 1));
            end
         endcase
         offer_beat(FUNC_CLASSIFY, site_idx_type'($urandom_range(0, 15)), x, y, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (nearest_pending.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending",
                                      rsp_chan.nearest_site));
         end else begin
            if (rsp_chan.nearest_site !== nearest_pending[0])
               report_mismatch($sformatf("nearest_site got %0d, want %0d",
                                         rsp_chan.nearest_site, nearest_pending[0]));
            void'(nearest_pending.pop_front());
            results_checked++;
         end
      end
   end

   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      #1_000_000;
      $display("Run timed out with %0d results still pending.", nearest_pending.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int noise;
      mismatch_count  = 0;
      results_checked = 0;
      beats_counted   = 0;
      loads_kept      = 0;
      loads_dropped   = 0;
      pixels_sent     = 0;
      tie_count       = 0;
      for (int i = 0; i < NUM_SITES; i++) begin
         site_x_copy[i] = '0;
         site_y_copy[i] = '0;
      end
      hold_off_wanted     <= 1'b0;
      quiet_phase         <= 1'b0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_LOAD;
      req_chan.site_index <= '0;
      req_chan.coord_x    <= '0;
      req_chan.coord_y    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_beat(directed_rows[i].func, directed_rows[i].site_index, directed_rows[i].x,
                    directed_rows[i].y, directed_rows[i].has_want, directed_rows[i].want);

      while (beats_counted < ITEM_TARGET) begin
         hold_off_wanted <= (beats_counted >= 300);
         quiet_phase     <= (beats_counted >= 800 && beats_counted < 1100);
         noise = $urandom_range(0, 9);
         if (noise == 0)
            offer_beat(func_type'($urandom_range(0, 1)), site_idx_type'($urandom_range(0, 15)),
                       coord_type'($urandom_range(0, COORD_MAX)),
                       coord_type'($urandom_range(0, COORD_MAX)), 1'b0, '0);
         else
            random_scene();
      end
      req_chan.valid <= 1'b0;
      quiet_phase    <= 1'b0;

      while (nearest_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d kept site loads, %0d dropped loads and %0d pixels (%0d with tied sites).",
               loads_kept, loads_dropped, pixels_sent, tie_count);
      $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0 && nearest_pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
